@@ src/indexed_array_insert_delete_defines.svh @@
// Assertion macros for the indexed list RTL.
// Included by modules that carry concurrent checks; depends on a clock named clk and reset rst.
`ifndef INDEXED_ARRAY_INSERT_DELETE_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_DELETE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define IAID_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define IAID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IAID_ASSERT_IMPL(label, ante, cons, msg)
`define IAID_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ src/iaid_pkg.sv @@
// Package for the indexed list block: sizes, codes and transaction structs.
// Used by every module of the block; depends on nothing.
package iaid_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 7;
  localparam int ENTRY_W    = 7;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Request transaction.
  typedef struct packed {
    op_t                      operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  // Result transaction.
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic [ENTRY_W-1:0]       entry_count;
  } res_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              shift_ins;
    logic              shift_del;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] item;
  } cell_ctl_t;

endpackage

@@ src/indexed_array_insert_delete.sv @@
// Top level of the indexed list with insert and delete at a position.
// Depends on iaid_pkg, iaid_cell, iaid_group and the assertion macro header.
//
// Usage:
//   A request transaction (operation, position, item_value) is taken at a
//   rising edge where start is high and busy is low. The list lives in a
//   chain of CAPACITY cells; on a request that passes its checks, each cell
//   at or above the position loads its neighbor or the item, all at once.
//   Exactly one result transaction follows each request: result_strobe is
//   high for one cycle, the cycle right after the accepting edge, with
//   status, removed_value and the entry count after the request.
//   A new request may be accepted every cycle.
//   The deleted entry is read through a registered OR tree (groups of eight
//   cells, then a final OR over the group registers).
//   A rejected request (full, empty or bad position) changes nothing.
//   Reset is synchronous: it clears the count and the result strobe and
//   holds busy high; cell contents are undefined until written.
//   The receiver cannot stall: each result must be taken when shown.
`include "indexed_array_insert_delete_defines.svh"

module indexed_array_insert_delete (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  iaid_pkg::req_t request,
  output logic           result_strobe,
  output iaid_pkg::res_t result
);

  localparam int PAD = iaid_pkg::NUM_GROUPS * iaid_pkg::GROUP;

  logic                          accept;
  logic [iaid_pkg::CNT_W-1:0]    count;
  logic [iaid_pkg::CNT_W-1:0]    count_next;
  logic [iaid_pkg::CMP_W-1:0]    pos_ext;
  logic [iaid_pkg::CMP_W-1:0]    count_ext;
  iaid_pkg::status_t             status_comb;
  logic                          ins_ok;
  logic                          del_ok;
  iaid_pkg::cell_ctl_t           ctl;

  logic [iaid_pkg::CAPACITY-1:0][iaid_pkg::DATA_W-1:0]   cell_data;
  logic [PAD-1:0][iaid_pkg::DATA_W-1:0]                  taps;
  logic [iaid_pkg::NUM_GROUPS-1:0][iaid_pkg::DATA_W-1:0] group_or;

  logic                          pend_del_ok;
  iaid_pkg::status_t             pend_status;
  logic [iaid_pkg::ENTRY_W-1:0]  pend_count;
  logic [iaid_pkg::DATA_W-1:0]   removed_comb;

  assign accept    = start && !busy;
  assign pos_ext   = iaid_pkg::CMP_W'(request.position);
  assign count_ext = iaid_pkg::CMP_W'(count);

  // Request checks: capacity and emptiness come before the position check.
  always_comb begin
    status_comb = iaid_pkg::ST_DONE;
    if (request.operation == iaid_pkg::OP_INSERT) begin
      if (count_ext >= iaid_pkg::CMP_W'(iaid_pkg::CAPACITY)) begin
        status_comb = iaid_pkg::ST_FULL;
      end else if (pos_ext > count_ext) begin
        status_comb = iaid_pkg::ST_RANGE;
      end
    end else begin
      if (count == '0) begin
        status_comb = iaid_pkg::ST_EMPTY;
      end else if (pos_ext >= count_ext) begin
        status_comb = iaid_pkg::ST_RANGE;
      end
    end
  end

  assign ins_ok = accept && (request.operation == iaid_pkg::OP_INSERT) &&
                  (status_comb == iaid_pkg::ST_DONE);
  assign del_ok = accept && (request.operation == iaid_pkg::OP_DELETE) &&
                  (status_comb == iaid_pkg::ST_DONE);

  // Count update for a successful insert or delete.
  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + 1'b1;
    end else if (del_ok) begin
      count_next = count - 1'b1;
    end
  end

  // Broadcast control to the cell chain.
  always_comb begin
    ctl.shift_ins = ins_ok;
    ctl.shift_del = del_ok;
    ctl.pos       = pos_ext;
    ctl.item      = request.item_value;
  end

  // The chain of cells; the ends see the item and their own data.
  for (genvar k = 0; k < iaid_pkg::CAPACITY; k++) begin : g_cell
    logic [iaid_pkg::DATA_W-1:0] left_in;
    logic [iaid_pkg::DATA_W-1:0] right_in;
    if (k == 0) begin : g_first
      assign left_in = request.item_value;
    end else begin : g_mid_l
      assign left_in = cell_data[k-1];
    end
    if (k == iaid_pkg::CAPACITY - 1) begin : g_last
      assign right_in = cell_data[k];
    end else begin : g_mid_r
      assign right_in = cell_data[k+1];
    end
    iaid_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (iaid_pkg::CMP_W'(k)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[k]),
      .tap        (taps[k])
    );
  end

  // Unused tap slots of a partial last group read as zero.
  for (genvar k = iaid_pkg::CAPACITY; k < PAD; k++) begin : g_pad
    assign taps[k] = '0;
  end

  // First level of the readout tree.
  for (genvar g = 0; g < iaid_pkg::NUM_GROUPS; g++) begin : g_group
    iaid_group u_group (
      .clk      (clk),
      .taps     (taps[g*iaid_pkg::GROUP +: iaid_pkg::GROUP]),
      .group_or (group_or[g])
    );
  end

  // Final OR over the group registers.
  always_comb begin
    removed_comb = '0;
    for (int g = 0; g < iaid_pkg::NUM_GROUPS; g++) begin
      removed_comb = removed_comb | group_or[g];
    end
  end

  // Control registers: count, result strobe and the busy flag held in reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      result_strobe <= 1'b0;
      busy          <= 1'b1;
    end else begin
      count         <= count_next;
      result_strobe <= accept;
      busy          <= 1'b0;
    end
  end

  // Result payload registers, aligned with the group registers.
  always_ff @(posedge clk) begin
    pend_del_ok <= del_ok;
    pend_status <= status_comb;
    pend_count  <= iaid_pkg::ENTRY_W'(count_next);
  end

  always_comb begin
    result.status        = pend_status;
    result.removed_value = pend_del_ok ? removed_comb : '0;
    result.entry_count   = pend_count;
  end

  // Checks on the block's own logic.
  `IAID_ASSERT_NEXT(a_one_result, accept, result_strobe, "missing result after request")
  `IAID_ASSERT_NEXT(a_no_spurious, !accept, !result_strobe, "result without request")
  `IAID_ASSERT_IMPL(a_count_cap, 1'b1, count <= iaid_pkg::CNT_W'(iaid_pkg::CAPACITY), "count over capacity")
  `IAID_ASSERT_NEXT(a_ins_count, ins_ok, count == iaid_pkg::CNT_W'($past(count) + 1'b1), "insert count")
  `IAID_ASSERT_IMPL(a_removed_zero, result_strobe && (result.status != iaid_pkg::ST_DONE), result.removed_value == '0, "removed value on rejected request")

endmodule

@@ src/iaid_cell.sv @@
// One storage cell of the list chain: holds a single entry.
// Depends on iaid_pkg; neighbors feed left_data and right_data.
module iaid_cell (
  input  logic                         clk,
  input  iaid_pkg::cell_ctl_t          ctl,
  input  logic [iaid_pkg::CMP_W-1:0]   idx,
  input  logic [iaid_pkg::DATA_W-1:0]  left_data,
  input  logic [iaid_pkg::DATA_W-1:0]  right_data,
  output logic [iaid_pkg::DATA_W-1:0]  data,
  output logic [iaid_pkg::DATA_W-1:0]  tap
);

  logic [iaid_pkg::DATA_W-1:0] data_next;

  // Insert moves entries at and above the position up and writes the item there; delete pulls later entries down.
  always_comb begin
    data_next = data;
    if (ctl.shift_ins) begin
      if (idx > ctl.pos) begin
        data_next = left_data;
      end else if (idx == ctl.pos) begin
        data_next = ctl.item;
      end
    end else if (ctl.shift_del) begin
      if (idx >= ctl.pos) begin
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // The cell at the requested position offers its entry to the readout tree.
  assign tap = (idx == ctl.pos) ? data : '0;

endmodule

@@ src/iaid_group.sv @@
// Registered OR of one group of cell taps, the first level of the readout tree.
// Depends on iaid_pkg for the group size and data width.
module iaid_group (
  input  logic                                      clk,
  input  logic [iaid_pkg::GROUP-1:0][iaid_pkg::DATA_W-1:0] taps,
  output logic [iaid_pkg::DATA_W-1:0]               group_or
);

  logic [iaid_pkg::DATA_W-1:0] or_comb;

  // At most one tap in the whole chain is nonzero, so OR selects it.
  always_comb begin
    or_comb = '0;
    for (int i = 0; i < iaid_pkg::GROUP; i++) begin
      or_comb = or_comb | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    group_or <= or_comb;
  end

endmodule
